>>> hdl/drt_pkg.sv
`timescale 1ns / 1ps

package drt_pkg;

   localparam int SCR_BITS      = 13;
   localparam int DATA_BITS     = 16;
   localparam int REQ_DATA_BITS = 64;
   localparam int RSP_DATA_BITS = 56;
   localparam int CMD_BITS      = 2;
   localparam int CSR_IDX_BITS  = 1;

   localparam logic [SCR_BITS-1:0] SCREEN_WIDTH_RST  = 13'd640;
   localparam logic [SCR_BITS-1:0] SCREEN_HEIGHT_RST = 13'd480;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCREEN_HEIGHT = 1'b1;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_MARK_RECT = 2'd0,
      CMD_MARK_ALL  = 2'd1,
      CMD_CONSUME   = 2'd2
   } cmd_type;

   // request payload, last field in the lowest bits
   typedef struct packed {
      logic [DATA_BITS-1:0] rect_height;
      logic [DATA_BITS-1:0] rect_width;
      logic [DATA_BITS-1:0] rect_y;
      logic [DATA_BITS-1:0] rect_x;
   } rect_type;

   typedef struct packed {
      logic                hit;
      logic [SCR_BITS-1:0] left;
      logic [SCR_BITS-1:0] top;
      logic [SCR_BITS-1:0] right;
      logic [SCR_BITS-1:0] bottom;
   } clip_rect_type;

   typedef struct packed {
      logic                found;
      logic [SCR_BITS-1:0] out_height;
      logic [SCR_BITS-1:0] out_width;
      logic [SCR_BITS-1:0] out_y;
      logic [SCR_BITS-1:0] out_x;
   } region_type;

   typedef struct packed {
      logic full_pending;
      logic box_active;
   } region_status_type;

endpackage

>>> hdl/drt_clip.sv
`timescale 1ns / 1ps

module drt_clip (
   input  drt_pkg::rect_type                rect,
   input  logic [drt_pkg::SCR_BITS-1:0]     screen_width,
   input  logic [drt_pkg::SCR_BITS-1:0]     screen_height,
   output drt_pkg::clip_rect_type           clip
);
   import drt_pkg::*;

   logic signed [DATA_BITS:0] x0;
   logic signed [DATA_BITS:0] y0;
   logic signed [DATA_BITS:0] w;
   logic signed [DATA_BITS:0] h;
   logic signed [DATA_BITS:0] x1;
   logic signed [DATA_BITS:0] y1;
   logic signed [DATA_BITS:0] sw;
   logic signed [DATA_BITS:0] sh;
   logic                      size_ok;
   logic                      on_screen;

   always_comb begin
      x0 = {rect.rect_x[DATA_BITS-1], rect.rect_x};
      y0 = {rect.rect_y[DATA_BITS-1], rect.rect_y};
      w  = {rect.rect_width[DATA_BITS-1], rect.rect_width};
      h  = {rect.rect_height[DATA_BITS-1], rect.rect_height};
      x1 = x0 + w;
      y1 = y0 + h;
      sw = {{(DATA_BITS + 1 - SCR_BITS){1'b0}}, screen_width};
      sh = {{(DATA_BITS + 1 - SCR_BITS){1'b0}}, screen_height};

      size_ok   = (w > 0) && (h > 0);
      on_screen = (x1 > 0) && (y1 > 0) && (x0 < sw) && (y0 < sh);

      clip.hit = size_ok && on_screen;
      // left and top lie below the screen size once on screen, so 13 bits hold them
      clip.left   = x0[DATA_BITS] ? '0 : x0[SCR_BITS-1:0];
      clip.top    = y0[DATA_BITS] ? '0 : y0[SCR_BITS-1:0];
      clip.right  = (x1 > sw) ? screen_width  : x1[SCR_BITS-1:0];
      clip.bottom = (y1 > sh) ? screen_height : y1[SCR_BITS-1:0];
   end

endmodule

>>> hdl/drt_region.sv
`timescale 1ns / 1ps

module drt_region #(
   parameter int COORD_BITS = 13
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             fire,
   input  drt_pkg::cmd_type                 cmd,
   input  drt_pkg::clip_rect_type           clip,
   input  logic [drt_pkg::SCR_BITS-1:0]     screen_width,
   input  logic [drt_pkg::SCR_BITS-1:0]     screen_height,
   output drt_pkg::region_type              region,
   output drt_pkg::region_status_type       status
);
   import drt_pkg::*;

   localparam int CW = (COORD_BITS > SCR_BITS) ? COORD_BITS : SCR_BITS;

   logic                  full_ff,   full_in;
   logic                  active_ff, active_in;
   logic [COORD_BITS-1:0] left_ff,   left_in;
   logic [COORD_BITS-1:0] top_ff,    top_in;
   logic [COORD_BITS-1:0] right_ff,  right_in;
   logic [COORD_BITS-1:0] bottom_ff, bottom_in;

   logic [CW-1:0]         rl_w, rt_w, rr_w, rb_w;
   logic [CW-1:0]         sw_w, sh_w, rst_w_w, rst_h_w;
   logic [COORD_BITS-1:0] rl_c, rt_c, rr_c, rb_c;
   logic [CW-1:0]         bl_w, bt_w, br_w, bb_w;
   logic [CW-1:0]         cr_w, cb_w;
   logic [CW-1:0]         dx_w, dy_w;
   logic                  box_empty;

   // bring clipped edges and screen size into the box coordinate width
   always_comb begin
      rl_w    = CW'(clip.left);
      rt_w    = CW'(clip.top);
      rr_w    = CW'(clip.right);
      rb_w    = CW'(clip.bottom);
      sw_w    = CW'(screen_width);
      sh_w    = CW'(screen_height);
      rst_w_w = CW'(SCREEN_WIDTH_RST);
      rst_h_w = CW'(SCREEN_HEIGHT_RST);
      rl_c    = rl_w[COORD_BITS-1:0];
      rt_c    = rt_w[COORD_BITS-1:0];
      rr_c    = rr_w[COORD_BITS-1:0];
      rb_c    = rb_w[COORD_BITS-1:0];
   end

   // consume: whole screen if full, else box clipped to current screen
   always_comb begin
      bl_w      = CW'(left_ff);
      bt_w      = CW'(top_ff);
      br_w      = CW'(right_ff);
      bb_w      = CW'(bottom_ff);
      cr_w      = (br_w > sw_w) ? sw_w : br_w;
      cb_w      = (bb_w > sh_w) ? sh_w : bb_w;
      box_empty = (cr_w <= bl_w) || (cb_w <= bt_w);
      dx_w      = cr_w - bl_w;
      dy_w      = cb_w - bt_w;

      region = '0;
      if (full_ff) begin
         region.found      = 1'b1;
         region.out_width  = screen_width;
         region.out_height = screen_height;
      end else if (active_ff && !box_empty) begin
         region.found      = 1'b1;
         region.out_x      = bl_w[SCR_BITS-1:0];
         region.out_y      = bt_w[SCR_BITS-1:0];
         region.out_width  = dx_w[SCR_BITS-1:0];
         region.out_height = dy_w[SCR_BITS-1:0];
      end
   end

   always_comb begin
      full_in   = full_ff;
      active_in = active_ff;
      left_in   = left_ff;
      top_in    = top_ff;
      right_in  = right_ff;
      bottom_in = bottom_ff;
      if (fire) begin
         case (cmd)
            CMD_MARK_RECT: begin
               if (clip.hit && !full_ff) begin
                  active_in = 1'b1;
                  if (!active_ff) begin
                     left_in   = rl_c;
                     top_in    = rt_c;
                     right_in  = rr_c;
                     bottom_in = rb_c;
                  end else begin
                     if (rl_c < left_ff)   left_in   = rl_c;
                     if (rt_c < top_ff)    top_in    = rt_c;
                     if (rr_c > right_ff)  right_in  = rr_c;
                     if (rb_c > bottom_ff) bottom_in = rb_c;
                  end
               end
            end
            CMD_MARK_ALL: begin
               full_in   = 1'b1;
               active_in = 1'b0;
               left_in   = '0;
               top_in    = '0;
               right_in  = sw_w[COORD_BITS-1:0];
               bottom_in = sh_w[COORD_BITS-1:0];
            end
            CMD_CONSUME: begin
               full_in   = 1'b0;
               active_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff   <= 1'b1;
         active_ff <= 1'b0;
         left_ff   <= '0;
         top_ff    <= '0;
         right_ff  <= rst_w_w[COORD_BITS-1:0];
         bottom_ff <= rst_h_w[COORD_BITS-1:0];
      end else begin
         full_ff   <= full_in;
         active_ff <= active_in;
         left_ff   <= left_in;
         top_ff    <= top_in;
         right_ff  <= right_in;
         bottom_ff <= bottom_in;
      end
   end

   assign status.full_pending = full_ff;
   assign status.box_active   = active_ff;

endmodule

>>> hdl/dirty_rectangle_tracker_unit.sv
`timescale 1ns / 1ps

// Dirty rectangle tracker. Requests on req_ carry a command in req_tuser: mark a
// rectangle, mark the whole screen, or consume the pending region. Only consume
// returns a response on rsp_; rsp_tuser is the found flag and rsp_tdata the region
// (all zero when nothing is found). The unit takes one request per clock: each
// request is held in the input register while the clip and box-merge logic
// updates the tracker state, and rsp_tvalid for a consume is registered as the
// consume leaves the input register. Throughput drops below one per cycle only
// while a consume waits for a held response to be taken. Screen size registers
// (index 0 width, index 1 height, reset 640 x 480) are written through csr_; the
// user must write them only while idle, which the block does not enforce.

module dirty_rectangle_tracker_unit #(
   parameter int COORD_BITS = 13
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // rect_x, rect_y, rect_width, rect_height
   input  logic [drt_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   // command
   input  logic [drt_pkg::CMD_BITS-1:0]          req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // out_x, out_y, out_width, out_height, zero pad
   output logic [drt_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   // found
   output logic [0:0]                            rsp_tuser,
   input  logic                                  csr_we,
   input  logic [drt_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [drt_pkg::SCR_BITS-1:0]          csr_wdata
);
   import drt_pkg::*;

   logic [SCR_BITS-1:0] scr_width_ff,  scr_width_in;
   logic [SCR_BITS-1:0] scr_height_ff, scr_height_in;

   logic                s1_valid_ff, s1_valid_in;
   cmd_type             s1_cmd_ff;
   rect_type            s1_rect_ff;
   logic                s1_is_consume;
   logic                s1_fire;

   logic                rsp_valid_ff, rsp_valid_in;
   region_type          rsp_region_ff;
   logic                out_free;

   clip_rect_type       clip;
   region_type          region;
   region_status_type   status;

   // configuration
   always_comb begin
      scr_width_in  = scr_width_ff;
      scr_height_in = scr_height_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  scr_width_in  = csr_wdata;
            CSR_SCREEN_HEIGHT: scr_height_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // handshake: hold a consume in the input register while the response is stuck
   always_comb begin
      out_free      = !rsp_valid_ff || rsp_tready;
      s1_is_consume = (s1_cmd_ff == CMD_CONSUME);
      s1_fire       = s1_valid_ff && (!s1_is_consume || out_free);
      req_tready    = !s1_valid_ff || s1_fire;
      s1_valid_in   = req_tready ? req_tvalid : s1_valid_ff;
      if (s1_fire && s1_is_consume) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scr_width_ff  <= SCREEN_WIDTH_RST;
         scr_height_ff <= SCREEN_HEIGHT_RST;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         scr_width_ff  <= scr_width_in;
         scr_height_ff <= scr_height_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_cmd_ff  <= cmd_type'(req_tuser);
         s1_rect_ff <= rect_type'(req_tdata);
      end
      if (s1_fire && s1_is_consume) begin
         rsp_region_ff <= region;
      end
   end

   drt_clip u_clip (
      .rect          (s1_rect_ff),
      .screen_width  (scr_width_ff),
      .screen_height (scr_height_ff),
      .clip          (clip)
   );

   drt_region #(
      .COORD_BITS (COORD_BITS)
   ) u_region (
      .clock         (clock),
      .reset         (reset),
      .fire          (s1_fire),
      .cmd           (s1_cmd_ff),
      .clip          (clip),
      .screen_width  (scr_width_ff),
      .screen_height (scr_height_ff),
      .region        (region),
      .status        (status)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_region_ff.found;
   assign rsp_tdata  = {{(RSP_DATA_BITS - 4 * SCR_BITS){1'b0}},
                        rsp_region_ff.out_height, rsp_region_ff.out_width,
                        rsp_region_ff.out_y, rsp_region_ff.out_x};

   // consume always drops both marks
   a_consume_clears: assert property (@(posedge clock) disable iff (reset)
      s1_fire && (s1_cmd_ff == CMD_CONSUME) |=> !status.full_pending && !status.box_active)
      else $error("consume left a mark pending");

   // mark-all sets the full mark and drops the box
   a_mark_all: assert property (@(posedge clock) disable iff (reset)
      s1_fire && (s1_cmd_ff == CMD_MARK_ALL) |=> status.full_pending && !status.box_active)
      else $error("mark-all state wrong");

   // a stuck consume must stall the request side
   a_consume_stall: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_is_consume && rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken over a stalled consume");

   // a not-found response carries an all-zero region
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> (rsp_tdata == '0))
      else $error("not-found response has nonzero region");

endmodule

>>> tb/tb_dirty_rectangle_tracker_unit.sv
`timescale 1ns / 1ps

module tb_dirty_rectangle_tracker_unit;
   import drt_pkg::*;

   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int NUM_PHASES  = 10;
   localparam int PHASE_ITEMS = 45;
   localparam int REPORT_MAX  = 10;

   typedef struct packed {
      logic [CMD_BITS-1:0] cmd;
      rect_type            rect;
      logic                typed;
      region_type          want;
   } stim_row;

   logic                     clock;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic [CMD_BITS-1:0]      req_tuser  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b1;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [0:0]               rsp_tuser;
   logic                     csr_we     = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index  = '0;
   logic [SCR_BITS-1:0]      csr_wdata  = '0;

   // tracker state as the testbench sees it
   logic [SCR_BITS-1:0] scr_w, scr_h;
   logic                full_mark, box_on;
   logic [SCR_BITS-1:0] box_l, box_t, box_r, box_b;

   region_type pending_regions [$];
   stim_row    dir_rows [$];
   int         phase_w [NUM_PHASES] = '{1, 4096, 0, 4096, 1, 0, 0, 0, 0, 640};
   int         phase_h [NUM_PHASES] = '{1, 4096, 0, 1, 4096, 0, 0, 0, 0, 480};
   int         fail_cnt   = 0;
   int         cycle_cnt  = 0;
   int         stall_left = 0;
   bit         idling_on  = 1'b1;

   dirty_rectangle_tracker_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic void mark_whole_screen();
      full_mark = 1'b1;
      box_on    = 1'b0;
      box_l     = '0;
      box_t     = '0;
      box_r     = scr_w;
      box_b     = scr_h;
   endfunction

   function automatic void predict_region(input logic [CMD_BITS-1:0] cmd, input rect_type r,
                                          output bit has_rsp, output region_type rsp);
      int x0, y0, x1, y1;
      logic [SCR_BITS-1:0] l, t, rgt, bot;
      has_rsp = 1'b0;
      rsp     = '0;
      case (cmd)
         CMD_MARK_RECT: begin
            x0 = int'($signed(r.rect_x));
            y0 = int'($signed(r.rect_y));
            x1 = x0 + int'($signed(r.rect_width));
            y1 = y0 + int'($signed(r.rect_height));
            // drop empty, negative and off-screen rectangles
            if ($signed(r.rect_width) <= 0 || $signed(r.rect_height) <= 0) return;
            if (x1 <= 0 || y1 <= 0 || x0 >= int'(scr_w) || y0 >= int'(scr_h)) return;
            // a pending full-screen mark already covers it
            if (full_mark) return;
            l   = SCR_BITS'((x0 < 0) ? 0 : x0);
            t   = SCR_BITS'((y0 < 0) ? 0 : y0);
            rgt = SCR_BITS'((x1 > int'(scr_w)) ? int'(scr_w) : x1);
            bot = SCR_BITS'((y1 > int'(scr_h)) ? int'(scr_h) : y1);
            if (!box_on) begin
               box_on = 1'b1;
               box_l  = l;
               box_t  = t;
               box_r  = rgt;
               box_b  = bot;
            end else begin
               if (l < box_l) box_l = l;
               if (t < box_t) box_t = t;
               if (rgt > box_r) box_r = rgt;
               if (bot > box_b) box_b = bot;
            end
         end
         CMD_MARK_ALL: mark_whole_screen();
         CMD_CONSUME: begin
            has_rsp = 1'b1;
            if (full_mark) begin
               full_mark      = 1'b0;
               box_on         = 1'b0;
               rsp.found      = 1'b1;
               rsp.out_width  = scr_w;
               rsp.out_height = scr_h;
            end else if (box_on) begin
               box_on = 1'b0;
               // clip the stored box to the screen in force now
               rgt = (box_r > scr_w) ? scr_w : box_r;
               bot = (box_b > scr_h) ? scr_h : box_b;
               if (rgt > box_l && bot > box_t) begin
                  rsp.found      = 1'b1;
                  rsp.out_x      = box_l;
                  rsp.out_y      = box_t;
                  rsp.out_width  = rgt - box_l;
                  rsp.out_height = bot - box_t;
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic rect_type pack_rect(input int x, input int y, input int w, input int h);
      rect_type r;
      r.rect_x      = 16'(x);
      r.rect_y      = 16'(y);
      r.rect_width  = 16'(w);
      r.rect_height = 16'(h);
      return r;
   endfunction

   function automatic stim_row make_row(input logic [CMD_BITS-1:0] cmd,
                                        input int x, input int y, input int w, input int h,
                                        input logic typed, input int found,
                                        input int ox, input int oy, input int ow, input int oh);
      stim_row row;
      row.cmd             = cmd;
      row.rect            = pack_rect(x, y, w, h);
      row.typed           = typed;
      row.want.found      = found[0];
      row.want.out_x      = SCR_BITS'(ox);
      row.want.out_y      = SCR_BITS'(oy);
      row.want.out_width  = SCR_BITS'(ow);
      row.want.out_height = SCR_BITS'(oh);
      return row;
   endfunction

   // mostly near the screen, now and then anywhere in the 16-bit range
   function automatic int pick_origin(input int span);
      if ($urandom_range(99) < 85) return int'($urandom_range(span + 128)) - 64;
      return int'($signed(16'($urandom)));
   endfunction

   function automatic int pick_extent(input int span);
      int k;
      k = $urandom_range(99);
      if (k < 50) return int'($urandom_range(1, 32));
      if (k < 85) return int'($urandom_range(1, span + 64));
      return int'($signed(16'($urandom)));
   endfunction

   task automatic send_request(input logic [CMD_BITS-1:0] cmd, input rect_type r,
                               input logic typed, input region_type typed_rsp);
      bit         hit;
      bit         has_rsp;
      region_type rsp;
      if (idling_on && $urandom_range(3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= r;
      req_tuser  <= cmd;
      // sample ready between edges, then take the request at the next edge
      do begin
         @(negedge clock);
         hit = req_tready;
         @(posedge clock);
      end while (!hit);
      predict_region(cmd, r, has_rsp, rsp);
      if (has_rsp) pending_regions.push_back(typed ? typed_rsp : rsp);
   endtask

   task automatic send_random_request();
      int                  k;
      logic [CMD_BITS-1:0] cmd;
      rect_type            r;
      k = $urandom_range(99);
      r = {$urandom, $urandom};
      if (k < 65) begin
         cmd = CMD_MARK_RECT;
         r   = pack_rect(pick_origin(int'(scr_w)), pick_origin(int'(scr_h)),
                         pick_extent(int'(scr_w)), pick_extent(int'(scr_h)));
      end else if (k < 70) begin
         cmd = CMD_MARK_ALL;
      end else if (k < 95) begin
         cmd = CMD_CONSUME;
      end else begin
         cmd = CMD_UNUSED;
      end
      send_request(cmd, r, 1'b0, '0);
   endtask

   // hold requests until every response is back and the pipeline is empty
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (pending_regions.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_screen(input logic [SCR_BITS-1:0] w, input logic [SCR_BITS-1:0] h);
      csr_we    <= 1'b1;
      csr_index <= CSR_SCREEN_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= CSR_SCREEN_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_we    <= 1'b0;
      scr_w = w;
      scr_h = h;
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idling_on && !reset && $urandom_range(7) == 0) begin
         stall_left <= $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(negedge clock) begin
      region_type want;
      region_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser[0], rsp_tdata[4*SCR_BITS-1:0]};
         if (pending_regions.size() == 0) begin
            fail_cnt++;
            if (fail_cnt <= REPORT_MAX)
               $display("unexpected response: found %0d x %0d y %0d w %0d h %0d",
                        got.found, got.out_x, got.out_y, got.out_width, got.out_height);
         end else begin
            want = pending_regions.pop_front();
            if (got.found !== want.found || got.out_x !== want.out_x ||
                got.out_y !== want.out_y || got.out_width !== want.out_width ||
                got.out_height !== want.out_height ||
                rsp_tdata[RSP_DATA_BITS-1:4*SCR_BITS] !== '0) begin
               fail_cnt++;
               if (fail_cnt <= REPORT_MAX)
                  $display({"region mismatch: expected found %0d x %0d y %0d w %0d h %0d,",
                            " got found %0d x %0d y %0d w %0d h %0d pad %h"},
                           want.found, want.out_x, want.out_y, want.out_width,
                           want.out_height, got.found, got.out_x, got.out_y, got.out_width,
                           got.out_height, rsp_tdata[RSP_DATA_BITS-1:4*SCR_BITS]);
            end
         end
      end
   end

   initial begin
      scr_w = SCREEN_WIDTH_RST;
      scr_h = SCREEN_HEIGHT_RST;
      mark_whole_screen();
      for (int p = 5; p < 9; p++) begin
         phase_w[p] = (p == 5) ? 0 : int'($urandom_range(1, 4096));
         phase_h[p] = int'($urandom_range(1, 4096));
      end

      dir_rows = '{
         // whole screen is dirty out of reset
         make_row(CMD_CONSUME,        0,      0,     0,      0, 1'b1, 1, 0, 0, 640, 480),
         make_row(CMD_CONSUME,        0,      0,     0,      0, 1'b1, 0, 0, 0,   0,   0),
         make_row(CMD_MARK_RECT,     10,     20,    30,     40, 1'b0, 0, 0, 0,   0,   0),
         make_row(CMD_MARK_RECT,     50,     50,     0,     10, 1'b0, 0, 0, 0,   0,   0),
         make_row(CMD_MARK_RECT,     50,     50,    10, -32768, 1'b0, 0, 0, 0,   0,   0),
         make_row(CMD_MARK_RECT,    640,      0,     5,      5, 1'b0, 0, 0, 0,   0,   0),
         make_row(CMD_MARK_RECT, -32768, -32768, 32767,  32767, 1'b0, 0, 0, 0,   0,   0),
         make_row(CMD_MARK_RECT,    -10,      5,    10,      5, 1'b0, 0, 0, 0,   0,   0),
         make_row(CMD_MARK_RECT,     -5,     -5,    10,     10, 1'b0, 0, 0, 0,   0,   0),
         make_row(CMD_UNUSED,     32767,     -1,    -1,     -1, 1'b0, 0, 0, 0,   0,   0),
         make_row(CMD_CONSUME,        0,      0,     0,      0, 1'b1, 1, 0, 0,  40,  60),
         make_row(CMD_MARK_RECT,  32767,  32767, 32767,  32767, 1'b0, 0, 0, 0,   0,   0),
         make_row(CMD_CONSUME,        0,      0,     0,      0, 1'b1, 0, 0, 0,   0,   0),
         make_row(CMD_MARK_ALL,       0,      0,     0,      0, 1'b0, 0, 0, 0,   0,   0),
         make_row(CMD_MARK_RECT,    100,    100,     5,      5, 1'b0, 0, 0, 0,   0,   0),
         make_row(CMD_CONSUME,        0,      0,     0,      0, 1'b1, 1, 0, 0, 640, 480),
         make_row(CMD_MARK_RECT,    600,    400, 32767,  32767, 1'b0, 0, 0, 0,   0,   0),
         make_row(CMD_MARK_RECT,    630,    470,    10,     10, 1'b0, 0, 0, 0,   0,   0),
         make_row(CMD_MARK_RECT,     20,     30,     1,      1, 1'b0, 0, 0, 0,   0,   0),
         make_row(CMD_CONSUME,        0,      0,     0,      0, 1'b1, 1, 20, 30, 620, 450)
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_request(dir_rows[i].cmd, dir_rows[i].rect, dir_rows[i].typed, dir_rows[i].want);

      // the box survives a screen resize and is clipped on consume
      send_request(CMD_MARK_RECT, pack_rect(500, 400, 100, 50), 1'b0, '0);
      drain_responses();
      set_screen(550, 420);
      send_request(CMD_CONSUME, pack_rect(0, 0, 0, 0), 1'b0, '0);
      // clipped to nothing by a smaller screen
      send_request(CMD_MARK_RECT, pack_rect(500, 400, 10, 10), 1'b0, '0);
      drain_responses();
      set_screen(300, 300);
      send_request(CMD_CONSUME, pack_rect(0, 0, 0, 0), 1'b0, '0);

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_responses();
         set_screen(SCR_BITS'(phase_w[p]), SCR_BITS'(phase_h[p]));
         idling_on = (p != NUM_PHASES - 1);
         repeat (PHASE_ITEMS) send_random_request();
      end

      drain_responses();
      repeat (6) @(posedge clock);
      if (fail_cnt == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> dirty_rectangle_tracker_unit.f
hdl/drt_pkg.sv
hdl/drt_clip.sv
hdl/drt_region.sv
hdl/dirty_rectangle_tracker_unit.sv
tb/tb_dirty_rectangle_tracker_unit.sv
